FILE: sv/pst_pkg.sv
// Shared types and constants for the priority schedule timing block.
// No dependencies; the interfaces, cell, top level and testbench import this package.
package pst_pkg;

  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 4;
  localparam int TIME_W  = 20;
  localparam int AVG_W   = 28;
  localparam int FRAC_W  = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [AVG_W-1:0]  AVG_MAX  = '1;

  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [ID_W-1:0]    id;
  } job_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

endpackage

FILE: sv/pst_if.sv
// Handshake interfaces for the job input and schedule row channels.
// Depends on pst_pkg for field widths.
interface pst_in_if import pst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BURST_W-1:0] burst_time;
  logic [PRIO_W-1:0]  priority_req;
  logic               last_job;

  modport source (output valid, burst_time, priority_req, last_job, input ready);
  modport sink   (input valid, burst_time, priority_req, last_job, output ready);
endinterface

interface pst_out_if import pst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    job_id;
  logic [PRIO_W-1:0]  job_priority;
  logic [BURST_W-1:0] job_burst;
  logic [TIME_W-1:0]  wait_time;
  logic [TIME_W-1:0]  turnaround_time;
  logic               last_row;
  logic [AVG_W-1:0]   avg_wait_q8;
  logic [AVG_W-1:0]   avg_turnaround_q8;
  logic               jobs_dropped;

  modport source (output valid, job_id, job_priority, job_burst, wait_time, turnaround_time,
                  last_row, avg_wait_q8, avg_turnaround_q8, jobs_dropped, input ready);
  modport sink   (input valid, job_id, job_priority, job_burst, wait_time, turnaround_time,
                  last_row, avg_wait_q8, avg_turnaround_q8, jobs_dropped, output ready);
endinterface

FILE: sv/pst_cell.sv
// One slot of the sorted job chain: stable insert by priority, shift left.
// Depends on pst_pkg.
module pst_cell import pst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cell_op_t op,
  input  job_t     new_job,
  input  job_t     left_job,
  input  logic     left_gb,
  input  job_t     right_job,
  output job_t     job,
  output logic     gb
);

  job_t job_r, job_nxt;

  // new job goes ahead of this slot only on a strictly smaller priority number
  assign gb  = job_r.valid && (new_job.prio < job_r.prio);
  assign job = job_r;

  always_comb begin
    job_nxt = job_r;
    case (op)
      CELL_INSERT: begin
        if (left_gb) begin
          job_nxt = left_job;
        end else if (gb) begin
          job_nxt = new_job;
        end else if (!job_r.valid && left_job.valid) begin
          job_nxt = new_job;
        end
      end
      CELL_SHIFT: job_nxt = right_job;
      default:    job_nxt = job_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r <= '0;
    end else begin
      job_r <= job_nxt;
    end
  end

endmodule

FILE: sv/pst_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module pst_div #(
  parameter int DW = 32,
  parameter int NW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [NW-1:0] rem_r;
  logic [NW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [NW:0]   rem_sh;
  logic [NW:0]   diff;
  logic          ge;

  assign rem_sh   = {rem_r, quo_r[DW-1]};
  assign diff     = rem_sh - {1'b0, den_r};
  assign ge       = rem_sh >= {1'b0, den_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(DW);
      quo_r  <= dividend;
      rem_r  <= '0;
      den_r  <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? diff[NW-1:0] : rem_sh[NW-1:0];
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

FILE: sv/priority_schedule_timing.sv
// Top level: non-preemptive priority schedule with wait and turnaround times.
// Depends on pst_pkg, pst_if, pst_cell and pst_div.
//
//   channel  dir  contents                                  handshake
//   in_ch    in   burst_time, priority_req, last_job        valid/ready
//   out_ch   out  job row, times, averages, drop flag       valid/ready
//
// Jobs load one per cycle while in S_LOAD into a chain of MAX_JOBS cells kept sorted on insert.
// After the last job the chain rotates once to total the times, then two serial
// dividers run side by side for the averages, then rows leave one per cycle, while
// the output is not stalled, through an output register.
// Reset clears the cell valid bits, counters and state; no clearing pass.
// A stalled output holds the chain; inputs are taken only while loading.
module priority_schedule_timing import pst_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  pst_in_if.sink    in_ch,
  pst_out_if.source out_ch
);

  localparam int NW  = $clog2(MAX_JOBS + 1);
  localparam int EW  = BURST_W + NW;
  localparam int SW  = TIME_W + NW;
  localparam int DW  = SW + FRAC_W;
  localparam int IXW = $clog2(MAX_JOBS);

  typedef enum logic [1:0] {S_LOAD, S_SUM, S_DIV, S_EMIT} state_t;

  state_t        state_r;
  logic [NW-1:0] count_r;
  logic          ovf_r;
  logic [NW-1:0] left_r;
  logic [IXW-1:0] idx_r;
  logic [EW-1:0] el_r;
  logic [SW-1:0] wsum_r;
  logic [SW-1:0] tsum_r;
  logic          div_start;
  logic          div_go_r;
  logic          wdone, tdone;
  logic [DW-1:0] wq, tq;

  job_t     chain   [MAX_JOBS];
  logic     gbv     [MAX_JOBS];
  job_t     new_job;
  job_t     tail_in;
  cell_op_t op;

  logic in_acc;
  logic out_load;
  logic [TIME_W-1:0] w_cur;
  logic [TIME_W:0]   t_raw;
  logic [TIME_W-1:0] t_cur;

  logic               out_v_r;
  logic [ID_W-1:0]    o_id_r;
  logic [PRIO_W-1:0]  o_prio_r;
  logic [BURST_W-1:0] o_burst_r;
  logic [TIME_W-1:0]  o_wait_r, o_turn_r;
  logic               o_last_r, o_drop_r;
  logic [AVG_W-1:0]   o_aw_r, o_at_r;

  assign in_ch.ready = (state_r == S_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_EMIT) && (!out_v_r || out_ch.ready);

  assign new_job = {1'b1, in_ch.priority_req, in_ch.burst_time, ID_W'(count_r)};

  always_comb begin
    op = CELL_HOLD;
    if (in_acc && (count_r < NW'(MAX_JOBS))) begin
      op = CELL_INSERT;
    end else if (state_r == S_SUM || out_load) begin
      op = CELL_SHIFT;
    end
  end

  // rotate while totaling, drain while emitting
  always_comb begin
    tail_in = chain[0];
    if (state_r != S_SUM) begin
      tail_in.valid = 1'b0;
    end
  end

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    job_t lj, rj;
    logic lg;
    if (i == 0) begin : g_head
      always_comb begin
        lj       = new_job;
        lj.valid = 1'b1;
      end
      assign lg = 1'b0;
    end else begin : g_mid
      assign lj = chain[i-1];
      assign lg = gbv[i-1];
    end
    if (i == MAX_JOBS - 1) begin : g_tail
      assign rj = tail_in;
    end else begin : g_body
      assign rj = chain[i+1];
    end
    pst_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (op),
      .new_job  (new_job),
      .left_job (lj),
      .left_gb  (lg),
      .right_job(rj),
      .job      (chain[i]),
      .gb       (gbv[i])
    );
  end

  assign w_cur = (el_r > EW'(TIME_MAX)) ? TIME_MAX : TIME_W'(el_r);
  assign t_raw = {1'b0, w_cur} + (TIME_W + 1)'(chain[0].burst);
  assign t_cur = t_raw[TIME_W] ? TIME_MAX : t_raw[TIME_W-1:0];

  assign div_start = (state_r == S_SUM) && (idx_r == IXW'(MAX_JOBS - 1));

  // start in the cycle after the rotation ends so the final sums are in place
  pst_div #(.DW(DW), .NW(NW)) u_wdiv (
    .clk(clk), .rst_n(rst_n), .start(div_go_r),
    .dividend({wsum_r, FRAC_W'(0)}), .divisor(count_r),
    .done(wdone), .quotient(wq)
  );

  pst_div #(.DW(DW), .NW(NW)) u_tdiv (
    .clk(clk), .rst_n(rst_n), .start(div_go_r),
    .dividend({tsum_r, FRAC_W'(0)}), .divisor(count_r),
    .done(tdone), .quotient(tq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      out_v_r  <= 1'b0;
      idx_r    <= '0;
      left_r   <= '0;
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= div_start;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (count_r < NW'(MAX_JOBS)) begin
              count_r <= count_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_ch.last_job) begin
              state_r <= S_SUM;
              idx_r   <= '0;
              el_r    <= '0;
              wsum_r  <= '0;
              tsum_r  <= '0;
            end
          end
        end
        S_SUM: begin
          if (chain[0].valid) begin
            el_r   <= el_r + EW'(chain[0].burst);
            wsum_r <= wsum_r + SW'(w_cur);
            tsum_r <= tsum_r + SW'(t_cur);
          end
          idx_r <= idx_r + 1'b1;
          if (div_start) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!div_go_r && wdone && tdone) begin
            state_r <= S_EMIT;
            el_r    <= '0;
            left_r  <= count_r;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            el_r   <= el_r + EW'(chain[0].burst);
            left_r <= left_r - 1'b1;
            if (left_r == NW'(1)) begin
              state_r <= S_LOAD;
              count_r <= '0;
              ovf_r   <= 1'b0;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
      // row payload
      if (out_load) begin
        o_id_r    <= chain[0].id;
        o_prio_r  <= chain[0].prio;
        o_burst_r <= chain[0].burst;
        o_wait_r  <= w_cur;
        o_turn_r  <= t_cur;
        o_last_r  <= (left_r == NW'(1));
        o_drop_r  <= ovf_r;
        if (left_r == NW'(1)) begin
          o_aw_r <= (wq > DW'(AVG_MAX)) ? AVG_MAX : AVG_W'(wq);
          o_at_r <= (tq > DW'(AVG_MAX)) ? AVG_MAX : AVG_W'(tq);
        end else begin
          o_aw_r <= '0;
          o_at_r <= '0;
        end
      end
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.job_id            = o_id_r;
  assign out_ch.job_priority      = o_prio_r;
  assign out_ch.job_burst         = o_burst_r;
  assign out_ch.wait_time         = o_wait_r;
  assign out_ch.turnaround_time   = o_turn_r;
  assign out_ch.last_row          = o_last_r;
  assign out_ch.avg_wait_q8       = o_aw_r;
  assign out_ch.avg_turnaround_q8 = o_at_r;
  assign out_ch.jobs_dropped      = o_drop_r;

  a_ovf_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && count_r == NW'(MAX_JOBS) && !in_ch.last_job) |=> ovf_r)
    else $error("dropped job not flagged");

  a_emit_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> chain[0].valid)
    else $error("emitting from an empty cell");

  a_set_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && left_r == NW'(1)) |=> (count_r == '0 && !ovf_r))
    else $error("set not cleared after last row");

  a_turn_ge: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (o_turn_r >= o_wait_r))
    else $error("turnaround below wait");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for priority_schedule_timing: loads job sets, predicts the sorted
// schedule rows and checks them field by field. Depends on pst_pkg, pst_if and the top level.
module testbench;
  import pst_pkg::*;

  localparam int N_JOBS = 16;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  wait_t;
    logic [TIME_W-1:0]  tat;
    logic               last;
    logic [AVG_W-1:0]   avg_w;
    logic [AVG_W-1:0]   avg_t;
    logic               dropped;
  } row_t;

  typedef struct {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               last;
    logic               chk;
    logic [ID_W-1:0]    e_id;
  } stim_t;

  logic clk = 0;
  logic rst_n = 0;
  pst_in_if  in_ch();
  pst_out_if out_ch();

  priority_schedule_timing #(.MAX_JOBS(N_JOBS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  row_t rows_pending[$];
  logic [BURST_W-1:0] set_burst[N_JOBS];
  logic [PRIO_W-1:0]  set_prio[N_JOBS];
  int   set_count = 0;
  bit   set_overflow = 0;
  int   fail_count = 0;
  int   quiet_cycles = 0;
  bit   stim_done = 0;
  bit   no_idle = 0;
  bit   hold_off = 0;
  bit   rand_phase = 0;
  stim_t directed[$];
  int   id_checks[$];

  // Update the schedule model with one accepted job; emit rows when it closes a set.
  task automatic schedule_job(input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p,
                              input logic l);
    int order[N_JOBS];
    int j;
    longint elapsed, wsum, tsum, w, t, q;
    row_t r;
    elapsed = 0; wsum = 0; tsum = 0;
    if (set_count < N_JOBS) begin
      set_burst[set_count] = b;
      set_prio[set_count] = p;
      set_count++;
    end else begin
      set_overflow = 1;
    end
    if (!l) return;
    for (int i = 0; i < set_count; i++) begin
      j = i;
      while (j > 0 && set_prio[order[j-1]] > set_prio[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int i = 0; i < set_count; i++) begin
      w = (elapsed > TIME_MAX) ? TIME_MAX : elapsed;
      t = w + set_burst[order[i]];
      if (t > TIME_MAX) t = TIME_MAX;
      wsum += w; tsum += t; elapsed += set_burst[order[i]];
      r.id = order[i][ID_W-1:0];
      r.prio = set_prio[order[i]];
      r.burst = set_burst[order[i]];
      r.wait_t = w[TIME_W-1:0];
      r.tat = t[TIME_W-1:0];
      r.last = (i + 1 == set_count);
      r.avg_w = '0;
      r.avg_t = '0;
      if (r.last) begin
        q = (wsum << FRAC_W) / set_count;
        r.avg_w = (q > AVG_MAX) ? AVG_MAX : q[AVG_W-1:0];
        q = (tsum << FRAC_W) / set_count;
        r.avg_t = (q > AVG_MAX) ? AVG_MAX : q[AVG_W-1:0];
      end
      r.dropped = set_overflow;
      rows_pending.push_back(r);
    end
    set_count = 0;
    set_overflow = 0;
  endtask

  task automatic send_job(input logic [BURST_W-1:0] b, input logic [PRIO_W-1:0] p,
                          input logic l);
    while (!no_idle && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.burst_time <= b;
    in_ch.priority_req <= p;
    in_ch.last_job <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    schedule_job(b, p, l);
  endtask

  task automatic add_row(input int b, input int p, input bit l, input bit chk = 0,
                         input int eid = 0);
    stim_t s;
    s.burst = BURST_W'(b); s.prio = PRIO_W'(p); s.last = l; s.chk = chk;
    s.e_id = ID_W'(eid);
    directed.push_back(s);
  endtask

  // Sender
  initial begin
    int len;
    in_ch.valid = 0;
    in_ch.burst_time = '0;
    in_ch.priority_req = '0;
    in_ch.last_job = 0;
    // single job set: row reads off directly (id 0, wait 0)
    add_row(16'hFFFF, 8'hFF, 1, 1, 0);
    add_row(0, 0, 1, 1, 0);
    // equal priorities keep arrival order
    add_row(5, 7, 0); add_row(9, 7, 0); add_row(3, 7, 1);
    // reversed priorities, extreme bursts
    add_row(16'hFFFF, 8'hFF, 0); add_row(16'hFFFF, 8'h80, 0);
    add_row(1, 8'h01, 0); add_row(16'h8000, 8'h00, 1);
    // overflow: 18 jobs, the last two dropped; the last still closes the set
    for (int i = 0; i < 18; i++) add_row(16'hFFFF - i, 255 - i, i == 17);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[k]) begin
      if (directed[k].chk) id_checks.push_back(directed[k].e_id);
      send_job(directed[k].burst, directed[k].prio, directed[k].last);
    end
    rand_phase = 1;
    for (int n = 0; n < 320; n += len) begin
      no_idle = (n >= 120 && n < 180);
      case ($urandom_range(9))
        0: len = $urandom_range(17, 20);
        1: len = 1;
        2: len = 16;
        default: len = $urandom_range(2, 8);
      endcase
      for (int i = 0; i < len; i++) begin
        logic [BURST_W-1:0] b;
        logic [PRIO_W-1:0] p;
        b = BURST_W'(($urandom_range(3) == 0) ? $urandom_range(3) : $urandom);
        p = PRIO_W'(($urandom_range(1) == 0) ? $urandom_range(3) : $urandom);
        send_job(b, p, i == len - 1);
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random stalls, one long hold-off
  initial begin
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_off && rand_phase) begin
        hold_off = 1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  // Row checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        row_t e;
        int exp_id;
        if (rows_pending.size() == 0) begin
          $display("%0t: unexpected row, expected none, actual id=%0d", $time, out_ch.job_id);
          fail_count++;
        end else begin
          e = rows_pending.pop_front();
          if (e.last && id_checks.size() > 0 && e.id == 0) begin
            exp_id = id_checks.pop_front();
            if (out_ch.job_id != exp_id) begin
              $display("%0t: directed id mismatch expected=%0d actual=%0d",
                       $time, exp_id, out_ch.job_id);
              fail_count++;
            end
          end
          if (out_ch.job_id !== e.id || out_ch.job_priority !== e.prio ||
              out_ch.job_burst !== e.burst || out_ch.wait_time !== e.wait_t ||
              out_ch.turnaround_time !== e.tat || out_ch.last_row !== e.last ||
              out_ch.avg_wait_q8 !== e.avg_w || out_ch.avg_turnaround_q8 !== e.avg_t ||
              out_ch.jobs_dropped !== e.dropped) begin
            $display("%0t: row mismatch expected id=%0d pr=%0d b=%0d w=%0d t=%0d l=%0d aw=%0d at=%0d d=%0d",
                     $time, e.id, e.prio, e.burst, e.wait_t, e.tat, e.last, e.avg_w,
                     e.avg_t, e.dropped);
            $display("%0t:          actual id=%0d pr=%0d b=%0d w=%0d t=%0d l=%0d aw=%0d at=%0d d=%0d",
                     $time, out_ch.job_id, out_ch.job_priority, out_ch.job_burst,
                     out_ch.wait_time, out_ch.turnaround_time, out_ch.last_row,
                     out_ch.avg_wait_q8, out_ch.avg_turnaround_q8, out_ch.jobs_dropped);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    wait (rst_n);
    while (!(stim_done && rows_pending.size() == 0) && quiet_cycles < WDOG_LIMIT)
      @(posedge clk);
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("%0t: timeout, %0d rows outstanding", $time, rows_pending.size());
      $display("*** FAILED ***");
    end else begin
      repeat (100) @(posedge clk);
      if (fail_count == 0 && rows_pending.size() == 0) begin
        $display("*** PASSED ***");
      end else begin
        $display("*** FAILED ***");
      end
    end
    $finish;
  end

endmodule
